>>> rtl/bcd_power_of_two_assert.svh
// ----------------------------------------------------------------------------
// bcd_power_of_two assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef BCD_POWER_OF_TWO_ASSERT_SVH
`define BCD_POWER_OF_TWO_ASSERT_SVH

// same-cycle implication
`define BCDP2_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bcd_power_of_two check failed");

// next-cycle implication
`define BCDP2_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bcd_power_of_two check failed");

`endif

>>> rtl/bcdp2_pkg.sv
// ----------------------------------------------------------------------------
// bcdp2_pkg
// types and constants shared by the power-of-two decimal expander
// ----------------------------------------------------------------------------
package bcdp2_pkg;

   localparam int DIGIT_W = 4;
   localparam int EXP_W   = 8;

   localparam logic [DIGIT_W-1:0] DIGIT_ZERO = 4'd0;
   localparam logic [DIGIT_W-1:0] DIGIT_ONE  = 4'd1;
   localparam logic [DIGIT_W-1:0] DIGIT_FIVE = 4'd5;
   localparam logic [DIGIT_W-1:0] DIGIT_TEN  = 4'd10;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DOUBLE,
      ST_SKIP,
      ST_EMIT,
      ST_OVER
   } state_type;

   typedef struct packed {
      logic load;
      logic dbl;
      logic shift;
   } cmd_type;

   typedef struct packed {
      logic [DIGIT_W-1:0] top_digit;
      logic               carry_out;
   } status_type;

endpackage

>>> rtl/bcdp2_datapath.sv
// ----------------------------------------------------------------------------
// bcdp2_datapath
// row of bcd digit cells: load one, double in place, shift toward the top
// ----------------------------------------------------------------------------
module bcdp2_datapath
   import bcdp2_pkg::*;
#(
   parameter int DIGITS = 64
) (
   input  logic       clock,
   input  cmd_type    cmd,
   output status_type status
);

   logic [DIGIT_W-1:0] digit_ff [DIGITS];
   logic [DIGIT_W-1:0] digit_in [DIGITS];

   always_comb begin
      for (int i = 0; i < DIGITS; i++) begin
         logic               carry;
         logic [DIGIT_W-1:0] twice;
         carry = 1'b0;
         if (i > 0) begin
            carry = (digit_ff[i-1] >= DIGIT_FIVE);
         end
         twice = {digit_ff[i][DIGIT_W-2:0], carry};
         if (digit_ff[i] >= DIGIT_FIVE) begin
            twice = twice - DIGIT_TEN;
         end
         digit_in[i] = digit_ff[i];
         if (cmd.load) begin
            digit_in[i] = (i == 0) ? DIGIT_ONE : DIGIT_ZERO;
         end else if (cmd.dbl) begin
            digit_in[i] = twice;
         end else if (cmd.shift) begin
            digit_in[i] = (i == 0) ? DIGIT_ZERO : digit_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DIGITS; i++) begin
         digit_ff[i] <= digit_in[i];
      end
   end

   assign status.top_digit = digit_ff[DIGITS-1];
   assign status.carry_out = (digit_ff[DIGITS-1] >= DIGIT_FIVE);

endmodule

>>> rtl/bcdp2_controller.sv
// ----------------------------------------------------------------------------
// bcdp2_controller
// sequencer: load, count doublings, flag overflow, skip leading zeros, emit digits
// ----------------------------------------------------------------------------
module bcdp2_controller
   import bcdp2_pkg::*;
#(
   parameter int DIGITS = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [EXP_W-1:0]   req_exponent,
   output logic               busy,
   output logic               rsp_valid,
   output logic [DIGIT_W-1:0] rsp_digit,
   output logic               rsp_last,
   output logic               rsp_overflow,
   output cmd_type            cmd,
   input  status_type         status
);

   localparam int POS_W = $clog2(DIGITS);
   localparam logic [POS_W-1:0] POS_TOP = POS_W'(DIGITS - 1);

   state_type        state_ff, state_in;
   logic [EXP_W-1:0] left_ff, left_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             over_ff, over_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         left_ff  <= '0;
         pos_ff   <= '0;
         over_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         left_ff  <= left_in;
         pos_ff   <= pos_in;
         over_ff  <= over_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      left_in      = left_ff;
      pos_in       = pos_ff;
      over_in      = over_ff;
      cmd          = '0;
      busy         = 1'b1;
      rsp_valid    = 1'b0;
      rsp_digit    = status.top_digit;
      rsp_last     = 1'b0;
      rsp_overflow = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               left_in  = req_exponent;
               over_in  = 1'b0;
               state_in = ST_DOUBLE;
            end
         end
         ST_DOUBLE: begin
            if (left_ff == '0) begin
               pos_in   = POS_TOP;
               state_in = over_ff ? ST_OVER : ST_SKIP;
            end else begin
               cmd.dbl = 1'b1;
               over_in = over_ff | status.carry_out;
               left_in = left_ff - 1'b1;
            end
         end
         ST_SKIP: begin
            if (status.top_digit == DIGIT_ZERO && pos_ff != '0) begin
               cmd.shift = 1'b1;
               pos_in    = pos_ff - 1'b1;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            rsp_last  = (pos_ff == '0);
            if (pos_ff == '0) begin
               state_in = ST_IDLE;
            end else begin
               cmd.shift = 1'b1;
               pos_in    = pos_ff - 1'b1;
            end
         end
         ST_OVER: begin
            rsp_valid    = 1'b1;
            rsp_digit    = DIGIT_ZERO;
            rsp_last     = 1'b1;
            rsp_overflow = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> rtl/bcd_power_of_two.sv
// ----------------------------------------------------------------------------
// bcd_power_of_two
// emits 2^n in decimal, one digit per response, most significant first
//
//   channel   ports                                      handshake
//   request   req_exponent                               start && !busy
//   response  rsp_digit, rsp_last, rsp_overflow          rsp_valid, one cycle
//
// one doubling of all digits per cycle, n doublings in all, then the zero skip
// and emission of the digits; busy stays high until the last response
// an overflowing exponent gives a single response with rsp_overflow set
// synchronous active-high reset returns to idle; the receiver cannot stall
// ----------------------------------------------------------------------------
module bcd_power_of_two
   import bcdp2_pkg::*;
#(
   parameter int DIGITS = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [EXP_W-1:0]   req_exponent,
   output logic               rsp_valid,
   output logic [DIGIT_W-1:0] rsp_digit,
   output logic               rsp_last,
   output logic               rsp_overflow
);

   cmd_type    cmd;
   status_type status;

   bcdp2_controller #(
      .DIGITS (DIGITS)
   ) u_controller (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .req_exponent (req_exponent),
      .busy         (busy),
      .rsp_valid    (rsp_valid),
      .rsp_digit    (rsp_digit),
      .rsp_last     (rsp_last),
      .rsp_overflow (rsp_overflow),
      .cmd          (cmd),
      .status       (status)
   );

   bcdp2_datapath #(
      .DIGITS (DIGITS)
   ) u_datapath (
      .clock  (clock),
      .cmd    (cmd),
      .status (status)
   );

endmodule

>>> rtl/bcdp2_checker.sv
// ----------------------------------------------------------------------------
// bcdp2_checker
// port-level checks on the power-of-two expander, bound to the top level
// ----------------------------------------------------------------------------
`include "bcd_power_of_two_assert.svh"

module bcdp2_checker
   import bcdp2_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic [EXP_W-1:0]   req_exponent,
   input logic               rsp_valid,
   input logic [DIGIT_W-1:0] rsp_digit,
   input logic               rsp_last,
   input logic               rsp_overflow
);

   logic unused_exponent;
   assign unused_exponent = ^req_exponent;

   `BCDP2_ASSERT_NOW(a_rsp_while_busy, rsp_valid, busy)
   `BCDP2_ASSERT_NOW(a_digit_decimal, rsp_valid, rsp_digit <= DIGIT_TEN - DIGIT_ONE)
   `BCDP2_ASSERT_NOW(a_overflow_ends, rsp_valid && rsp_overflow, rsp_last && rsp_digit == DIGIT_ZERO)
   `BCDP2_ASSERT_NEXT(a_last_frees, rsp_valid && rsp_last, !busy)
   `BCDP2_ASSERT_NEXT(a_start_takes, start && !busy, busy && !rsp_valid)

endmodule

bind bcd_power_of_two bcdp2_checker u_checker (.*);
